@@ rtl/cnms_pkg.sv @@
// Shared types, constants and helpers for the Canny non-maximum suppression core.
// Used by cnms_front, cnms_suppress and canny_non_maximum_suppression_core.
// Depends on nothing else.
`timescale 1ns / 1ps

package cnms_pkg;

    // Geometry and data widths.
    localparam int MAX_WIDTH    = 2048;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int MAG_BITS     = 16;
    localparam int ANGLE_BITS   = 12;
    localparam int CFG_BITS     = 12;
    localparam int CFG_IDX_BITS = 2;
    localparam int COL_BITS     = $clog2(MAX_WIDTH);
    localparam int ROW_BITS     = 12;
    localparam int MIN_DIM      = 3;

    // Register reset values.
    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = CFG_IDX_BITS'(1);

    // Angle thresholds in tenths of a degree.
    localparam int FOLD_TENTHS = 1800;
    localparam int EDGE_0      = 225;
    localparam int EDGE_1      = 675;
    localparam int EDGE_2      = 1125;
    localparam int EDGE_3      = 1575;

    // Quantized gradient direction and the neighbor pair it selects.
    typedef enum logic [1:0] {
        DIR_HORZ      = 2'd0,   // left and right
        DIR_DIAG_DOWN = 2'd1,   // up-left and down-right
        DIR_VERT      = 2'd2,   // up and down
        DIR_DIAG_UP   = 2'd3    // up-right and down-left
    } dir_t;

    // Which neighbors of the center lie inside the image.
    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } border_t;

    // One accepted item handed from the front stage to the compare stage.
    typedef struct packed {
        logic [MAG_BITS-1:0] mag;
        dir_t                dir;
        logic [COL_BITS-1:0] col;
        logic                produce;
        logic                last;
        border_t             border;
    } item_t;

    // One entry of the line memory: two rows of magnitude and one row of direction.
    typedef struct packed {
        logic [MAG_BITS-1:0] top;
        logic [MAG_BITS-1:0] mid;
        dir_t                dir;
    } line_word_t;

    localparam int LINE_BITS = $bits(line_word_t);

    // One window column: rows above, at and below the center row.
    typedef struct packed {
        logic [MAG_BITS-1:0] top;
        logic [MAG_BITS-1:0] mid;
        logic [MAG_BITS-1:0] bot;
    } column_t;

    // Fold the angle modulo 180 degrees and quantize it to four directions.
    function automatic dir_t quantize_angle(input logic [ANGLE_BITS-1:0] tenths);
        logic [ANGLE_BITS-1:0] a;
        dir_t                  d;
        if (tenths >= ANGLE_BITS'(2 * FOLD_TENTHS))
            a = tenths - ANGLE_BITS'(2 * FOLD_TENTHS);
        else if (tenths >= ANGLE_BITS'(FOLD_TENTHS))
            a = tenths - ANGLE_BITS'(FOLD_TENTHS);
        else
            a = tenths;
        if (a <= ANGLE_BITS'(EDGE_0) || a > ANGLE_BITS'(EDGE_3))
            d = DIR_HORZ;
        else if (a <= ANGLE_BITS'(EDGE_1))
            d = DIR_DIAG_DOWN;
        else if (a <= ANGLE_BITS'(EDGE_2))
            d = DIR_VERT;
        else
            d = DIR_DIAG_UP;
        return d;
    endfunction

endpackage

@@ rtl/cnms_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module cnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds while rd_en is low.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/cnms_front.sv @@
// Front stage: configuration registers, raster position counters, angle quantizer
// and the line memory read. Depends on cnms_pkg.
`timescale 1ns / 1ps

module cnms_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input pixel channel.
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [cnms_pkg::MAG_BITS-1:0]        pixel_magnitude,
    input  logic [cnms_pkg::ANGLE_BITS-1:0]      angle_tenths,
    input  logic                                 flush,
    // Configuration channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [cnms_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [cnms_pkg::CFG_BITS-1:0]        cfg_data,
    // Compare stage status.
    input  logic                                 hold,
    input  logic                                 busy,
    // Item to the compare stage and line memory read.
    output logic                                 go,
    output cnms_pkg::item_t                      item,
    output logic                                 rd_en,
    output logic [cnms_pkg::COL_BITS-1:0]        rd_addr
);

    logic [cnms_pkg::CFG_BITS-1:0] width_reg,  width_next;
    logic [cnms_pkg::CFG_BITS-1:0] height_reg, height_next;
    logic [cnms_pkg::COL_BITS-1:0] col_reg,    col_next;
    logic [cnms_pkg::ROW_BITS-1:0] row_reg,    row_next;

    logic                          accept;
    logic                          cfg_write;
    logic                          restart;
    logic                          draining;
    logic                          drop;
    logic [cnms_pkg::COL_BITS-1:0] col_cur;
    logic                          col_first;
    logic [cnms_pkg::CFG_BITS-1:0] col_inc;
    logic [cnms_pkg::ROW_BITS-1:0] height_plus;
    logic [cnms_pkg::CFG_BITS-1:0] width_clamped;
    logic [cnms_pkg::CFG_BITS-1:0] height_clamped;

    // Handshakes: the compare stage can take an item unless it is stalled.
    assign in_ready  = !hold;
    assign cfg_ready = !busy;
    assign accept    = in_valid && in_ready;
    assign cfg_write = cfg_valid && cfg_ready;

    // Position of this transaction; past the last row every item drains the window.
    assign draining    = row_reg >= cnms_pkg::ROW_BITS'(height_reg);
    assign drop        = !draining && flush;
    assign go          = accept && !drop;
    assign col_cur     = (cnms_pkg::CFG_BITS'(col_reg) >= width_reg) ? '0 : col_reg;
    assign col_first   = col_cur == '0;
    assign col_inc     = cnms_pkg::CFG_BITS'(col_cur) + cnms_pkg::CFG_BITS'(1);
    assign height_plus = cnms_pkg::ROW_BITS'(height_reg) + cnms_pkg::ROW_BITS'(1);

    // The center sits one row and one column behind; at column zero it is
    // the right end of the row two above.
    always_comb
    begin
        item.mag     = draining ? '0 : pixel_magnitude;
        item.dir     = draining ? cnms_pkg::DIR_HORZ : cnms_pkg::quantize_angle(angle_tenths);
        item.col     = col_cur;
        item.produce = (row_reg >= cnms_pkg::ROW_BITS'(2))
                       || (row_reg == cnms_pkg::ROW_BITS'(1) && !col_first);
        item.last    = col_first && row_reg == height_plus;
        item.border.top_ok   = col_first ? (row_reg != cnms_pkg::ROW_BITS'(2))
                                         : (row_reg != cnms_pkg::ROW_BITS'(1));
        item.border.bot_ok   = col_first ? (row_reg != height_plus)
                                         : (row_reg != cnms_pkg::ROW_BITS'(height_reg));
        item.border.left_ok  = col_cur != cnms_pkg::COL_BITS'(1);
        item.border.right_ok = !col_first;
    end

    assign rd_en   = go;
    assign rd_addr = col_cur;

    // Out-of-range register values are clamped when written.
    always_comb
    begin
        if (cfg_data < cnms_pkg::CFG_BITS'(cnms_pkg::MIN_DIM))
            width_clamped = cnms_pkg::CFG_BITS'(cnms_pkg::MIN_DIM);
        else if (cfg_data > cnms_pkg::CFG_BITS'(cnms_pkg::MAX_WIDTH))
            width_clamped = cnms_pkg::CFG_BITS'(cnms_pkg::MAX_WIDTH);
        else
            width_clamped = cfg_data;

        if (cfg_data < cnms_pkg::CFG_BITS'(cnms_pkg::MIN_DIM))
            height_clamped = cnms_pkg::CFG_BITS'(cnms_pkg::MIN_DIM);
        else if (cfg_data > cnms_pkg::CFG_BITS'(cnms_pkg::HEIGHT_LIMIT))
            height_clamped = cnms_pkg::CFG_BITS'(cnms_pkg::HEIGHT_LIMIT);
        else
            height_clamped = cfg_data;
    end

    // Register writes and position counter update.
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        restart     = 1'b0;
        if (cfg_write)
        begin
            unique case (cfg_index)
                cnms_pkg::CFG_IDX_WIDTH:
                begin
                    width_next = width_clamped;
                    restart    = 1'b1;
                end
                cnms_pkg::CFG_IDX_HEIGHT:
                begin
                    height_next = height_clamped;
                    restart     = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end

        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (go)
        begin
            if (item.produce && item.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_inc >= width_reg)
            begin
                col_next = '0;
                row_next = row_reg + cnms_pkg::ROW_BITS'(1);
            end
            else
            begin
                col_next = col_inc[cnms_pkg::COL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= cnms_pkg::CFG_BITS'(cnms_pkg::WIDTH_RESET);
            height_reg <= cnms_pkg::CFG_BITS'(cnms_pkg::HEIGHT_RESET);
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // The column counter stays inside the row.
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        cnms_pkg::CFG_BITS'(col_reg) < width_reg)
        else $error("column counter beyond image width");

    // The row counter never passes the end of the drain row.
    a_row_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= height_plus)
        else $error("row counter beyond drain row");

endmodule

@@ rtl/cnms_suppress.sv @@
// Compare stage: line memory write-back, 3x3 window columns, neighbor compare
// and the result register. Depends on cnms_pkg.
`timescale 1ns / 1ps

module cnms_suppress (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Item from the front stage.
    input  logic                                 go,
    input  cnms_pkg::item_t                      item,
    output logic                                 hold,
    output logic                                 busy,
    // Line memory read data and write-back.
    input  logic [cnms_pkg::LINE_BITS-1:0]       rd_data,
    output logic                                 wr_en,
    output logic [cnms_pkg::COL_BITS-1:0]        wr_addr,
    output logic [cnms_pkg::LINE_BITS-1:0]       wr_data,
    // Result channel.
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [cnms_pkg::MAG_BITS-1:0]        kept_magnitude,
    output logic                                 frame_last
);

    logic                          s1_valid_reg, s1_valid_next;
    cnms_pkg::item_t               s1_item_reg;
    cnms_pkg::column_t             left_reg;
    cnms_pkg::column_t             cent_reg;
    cnms_pkg::dir_t                dir_right_reg;
    logic                          out_valid_reg;
    logic [cnms_pkg::MAG_BITS-1:0] kept_reg;
    logic                          last_reg;

    cnms_pkg::line_word_t          line_rd;
    cnms_pkg::line_word_t          line_wr;
    logic                          fire;
    logic                          a_ok, b_ok;
    logic [cnms_pkg::MAG_BITS-1:0] a_mag, b_mag;
    logic [cnms_pkg::MAG_BITS-1:0] centre;
    logic                          suppressed;
    logic [cnms_pkg::MAG_BITS-1:0] kept_value;

    // The stage retires its item unless it has a result and the output is full.
    assign fire = s1_valid_reg
                  && (!s1_item_reg.produce || !out_valid_reg || out_ready);
    assign hold = s1_valid_reg && !fire;
    assign busy = s1_valid_reg;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (go)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
    end

    // Line memory shifts up a row: old middle becomes top, the new pixel middle.
    assign line_rd       = cnms_pkg::line_word_t'(rd_data);
    assign line_wr.top   = line_rd.mid;
    assign line_wr.mid   = s1_item_reg.mag;
    assign line_wr.dir   = s1_item_reg.dir;
    assign wr_en         = fire;
    assign wr_addr       = s1_item_reg.col;
    assign wr_data       = cnms_pkg::LINE_BITS'(line_wr);

    // Select the two neighbors along the center's direction. The right column
    // is the one just read from the line memory plus the incoming pixel.
    assign centre = cent_reg.mid;

    always_comb
    begin
        case (dir_right_reg)
            cnms_pkg::DIR_HORZ:
            begin
                a_ok  = s1_item_reg.border.left_ok;
                a_mag = left_reg.mid;
                b_ok  = s1_item_reg.border.right_ok;
                b_mag = line_rd.mid;
            end
            cnms_pkg::DIR_DIAG_DOWN:
            begin
                a_ok  = s1_item_reg.border.top_ok && s1_item_reg.border.left_ok;
                a_mag = left_reg.top;
                b_ok  = s1_item_reg.border.bot_ok && s1_item_reg.border.right_ok;
                b_mag = s1_item_reg.mag;
            end
            cnms_pkg::DIR_VERT:
            begin
                a_ok  = s1_item_reg.border.top_ok;
                a_mag = cent_reg.top;
                b_ok  = s1_item_reg.border.bot_ok;
                b_mag = cent_reg.bot;
            end
            cnms_pkg::DIR_DIAG_UP:
            begin
                a_ok  = s1_item_reg.border.top_ok && s1_item_reg.border.right_ok;
                a_mag = line_rd.top;
                b_ok  = s1_item_reg.border.bot_ok && s1_item_reg.border.left_ok;
                b_mag = left_reg.bot;
            end
            default:
            begin
                a_ok  = 1'b0;
                a_mag = '0;
                b_ok  = 1'b0;
                b_mag = '0;
            end
        endcase
    end

    // Neighbors outside the image are masked before they can suppress.
    assign suppressed = (a_ok && (centre < a_mag)) || (b_ok && (centre < b_mag));
    assign kept_value = suppressed ? '0 : centre;

    // Window columns and direction pipeline advance with each retired item.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s1_item_reg <= item;
        end
        if (fire)
        begin
            left_reg      <= cent_reg;
            cent_reg.top  <= line_rd.top;
            cent_reg.mid  <= line_rd.mid;
            cent_reg.bot  <= s1_item_reg.mag;
            dir_right_reg <= line_rd.dir;
        end
        if (fire && s1_item_reg.produce)
        begin
            kept_reg <= kept_value;
            last_reg <= s1_item_reg.last;
        end
    end

    // Stage valid and result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (fire && s1_item_reg.produce)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign kept_magnitude = kept_reg;
    assign frame_last     = last_reg;

    // A retired item with a result always shows up in the result register.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_item_reg.produce |=> out_valid_reg)
        else $error("result lost on its way to the output register");

    // A stalled item keeps its place and its memory address.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        hold |=> s1_valid_reg && $stable(s1_item_reg.col))
        else $error("stalled item changed");

    // The front never pushes into a stalled stage.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> !hold)
        else $error("item accepted while compare stage stalled");

endmodule

@@ rtl/canny_non_maximum_suppression_core.sv @@
// Top level of the Canny non-maximum suppression core (3x3 window, raster stream).
// Depends on cnms_pkg, cnms_ram, cnms_front and cnms_suppress.
//
//  Channel | Signals                                           | Direction
//  --------+---------------------------------------------------+----------
//  input   | in_valid/in_ready, pixel_magnitude, angle_tenths, | in
//          | flush                                             |
//  result  | out_valid/out_ready, kept_magnitude, frame_last   | out
//  config  | cfg_valid/cfg_ready, cfg_index, cfg_data          | in
//
// One transaction per clock is sustained unless the compare stage stalls; the
// transaction that completes a window is registered with its line memory read
// data, and the result register loads when the compare stage retires it.
// Results trail the input by one row plus one pixel, so a frame needs
// image_width + 1 further transactions, flush or not, after its last pixel.
// Reset clears control only; the line memory is not cleared and needs no pass.
// A result waiting in the output register stalls the compare stage only when
// the next item also has a result; cfg_ready is low while that stage is busy.
`timescale 1ns / 1ps

module canny_non_maximum_suppression_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [cnms_pkg::MAG_BITS-1:0]      pixel_magnitude,
    input  logic [cnms_pkg::ANGLE_BITS-1:0]    angle_tenths,
    input  logic                               flush,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [cnms_pkg::MAG_BITS-1:0]      kept_magnitude,
    output logic                               frame_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cnms_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [cnms_pkg::CFG_BITS-1:0]      cfg_data
);

    logic                              go;
    cnms_pkg::item_t                   item;
    logic                              hold;
    logic                              busy;
    logic                              rd_en;
    logic [cnms_pkg::COL_BITS-1:0]     rd_addr;
    logic [cnms_pkg::LINE_BITS-1:0]    rd_data;
    logic                              wr_en;
    logic [cnms_pkg::COL_BITS-1:0]     wr_addr;
    logic [cnms_pkg::LINE_BITS-1:0]    wr_data;

    // Position counters, quantizer and line memory read.
    cnms_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel_magnitude (pixel_magnitude),
        .angle_tenths    (angle_tenths),
        .flush           (flush),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .hold            (hold),
        .busy            (busy),
        .go              (go),
        .item            (item),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr)
    );

    // Two magnitude rows and one direction row, one entry per column.
    cnms_ram #(
        .WIDTH (cnms_pkg::LINE_BITS),
        .DEPTH (cnms_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Window, neighbor compare and result register.
    cnms_suppress u_suppress (
        .clk            (clk),
        .rst_n          (rst_n),
        .go             (go),
        .item           (item),
        .hold           (hold),
        .busy           (busy),
        .rd_data        (rd_data),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kept_magnitude (kept_magnitude),
        .frame_last     (frame_last)
    );

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for canny_non_maximum_suppression_core.
// Depends on cnms_pkg for widths, register indexes and direction codes; holds its own
// cycle-free 3x3 suppression predictor; checks each result against it or a hand-set value.
`timescale 1ns / 1ps

module tb;

    import cnms_pkg::*;

    // Register slots that the core does not implement; writes to them are ignored.
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_A = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_B = CFG_IDX_BITS'(3);

    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 8;
    localparam int TAIL_TICKS   = 20;
    localparam int RANDOM_ITEMS = 650;
    localparam int WIDE_PIXELS  = 40;
    localparam int TALL_PIXELS  = 60;

    // One stimulus row: pixel fields plus an optional hand-written expectation.
    typedef struct packed {
        logic [MAG_BITS-1:0]   mag;
        logic [ANGLE_BITS-1:0] ang;
        logic                  fl;
        logic                  fixed_exp;
        logic [MAG_BITS-1:0]   exp_kept;
        logic                  exp_last;
    } nms_vector_t;

    // One expected result transaction.
    typedef struct packed {
        logic [MAG_BITS-1:0] kept;
        logic                last;
    } nms_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [MAG_BITS-1:0]     pixel_magnitude = '0;
    logic [ANGLE_BITS-1:0]   angle_tenths = '0;
    logic                    flush = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [MAG_BITS-1:0]     kept_magnitude;
    logic                    frame_last;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_BITS-1:0]     cfg_data = '0;

    // Handshake and output values sampled mid-cycle, acted on at the next rising edge.
    bit                      in_fire;
    bit                      out_fire;
    bit                      cfg_fire;
    logic [MAG_BITS-1:0]     kept_seen;
    logic                    last_seen;

    bit                      steady = 1'b0;
    int                      errors = 0;
    int                      items_sent = 0;
    int                      results_seen = 0;
    int                      frames_done = 0;
    int                      reg_writes = 0;
    int                      stall_count = 0;

    nms_result_t             pending_results [$];

    // Predictor state: two magnitude rows, one direction row, the window and positions.
    bit [MAG_BITS-1:0]       line_mag [0:2*MAX_WIDTH-1];
    bit [1:0]                line_dir [0:MAX_WIDTH-1];
    bit [MAG_BITS-1:0]       win [0:2][0:2];
    bit [1:0]                dir_centre = '0;
    bit [1:0]                dir_next = '0;
    int                      col_pos = 0;
    int                      row_pos = 0;
    logic [CFG_BITS-1:0]     width_reg = CFG_BITS'(WIDTH_RESET);
    logic [CFG_BITS-1:0]     height_reg = CFG_BITS'(HEIGHT_RESET);

    // Directed rows: a 3x3 frame with stray flushes, a pixel dropped while draining,
    // all angle boundaries and magnitude extremes.
    nms_vector_t directed_rows [16] = '{
        '{16'd0,     12'd0,    1'b1, 1'b0, 16'd0,     1'b0},
        '{16'd65535, 12'd0,    1'b0, 1'b0, 16'd0,     1'b0},
        '{16'd0,     12'd3599, 1'b0, 1'b0, 16'd0,     1'b0},
        '{16'd65535, 12'd226,  1'b0, 1'b0, 16'd0,     1'b0},
        '{16'd0,     12'd0,    1'b1, 1'b0, 16'd0,     1'b0},
        '{16'd1,     12'd675,  1'b0, 1'b0, 16'd0,     1'b0},
        '{16'd65535, 12'd676,  1'b0, 1'b1, 16'd65535, 1'b0},
        '{16'd2,     12'd1125, 1'b0, 1'b0, 16'd0,     1'b0},
        '{16'd3,     12'd1126, 1'b0, 1'b1, 16'd65535, 1'b0},
        '{16'd4,     12'd1575, 1'b0, 1'b0, 16'd0,     1'b0},
        '{16'd65535, 12'd1576, 1'b0, 1'b1, 16'd65535, 1'b0},
        '{16'd0,     12'd0,    1'b1, 1'b0, 16'd0,     1'b0},
        '{16'd65535, 12'd4095, 1'b0, 1'b0, 16'd0,     1'b0},
        '{16'd0,     12'd0,    1'b1, 1'b0, 16'd0,     1'b0},
        '{16'd0,     12'd0,    1'b1, 1'b1, 16'd65535, 1'b1},
        '{16'd0,     12'd225,  1'b1, 1'b0, 16'd0,     1'b0}
    };

    canny_non_maximum_suppression_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .pixel_magnitude (pixel_magnitude),
        .angle_tenths    (angle_tenths),
        .flush           (flush),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kept_magnitude  (kept_magnitude),
        .frame_last      (frame_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Inputs only change at rising edges, so the falling edge sees what the next edge takes.
    always @(negedge clk)
    begin
        in_fire   = (in_valid === 1'b1) && (in_ready === 1'b1);
        out_fire  = (out_valid === 1'b1) && (out_ready === 1'b1);
        cfg_fire  = (cfg_valid === 1'b1) && (cfg_ready === 1'b1);
        kept_seen = kept_magnitude;
        last_seen = frame_last;
    end

    // Sizes as the core uses them, clamped to the supported range.
    function automatic int width_used();
        if (width_reg < MIN_DIM) return MIN_DIM;
        if (width_reg > MAX_WIDTH) return MAX_WIDTH;
        return int'(width_reg);
    endfunction

    function automatic int height_used();
        if (height_reg < MIN_DIM) return MIN_DIM;
        if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return int'(height_reg);
    endfunction

    // Fold modulo 180 degrees, then pick the nearest of four directions.
    function automatic bit [1:0] angle_to_dir(input logic [ANGLE_BITS-1:0] tenths);
        int a;
        a = int'(tenths) % FOLD_TENTHS;
        if (a <= EDGE_0 || a > EDGE_3) return DIR_HORZ;
        if (a <= EDGE_1) return DIR_DIAG_DOWN;
        if (a <= EDGE_2) return DIR_VERT;
        return DIR_DIAG_UP;
    endfunction

    // Advance the predictor by one accepted transaction; reports the result it causes.
    task automatic nms_step(input logic [MAG_BITS-1:0] mag_in,
                            input logic [ANGLE_BITS-1:0] ang_in, input logic fl,
                            output bit produced, output nms_result_t res);
        int                w;
        int                h;
        int                c;
        int                r;
        int                cr;
        int                cc;
        int                dr;
        int                dc;
        int                nr;
        int                nc;
        int                k;
        bit                draining;
        bit [MAG_BITS-1:0] mag;
        bit [MAG_BITS-1:0] top;
        bit [MAG_BITS-1:0] mid;
        bit [MAG_BITS-1:0] centre;
        bit [MAG_BITS-1:0] kept;
        bit [1:0]          d;
        w = width_used();
        h = height_used();
        draining = (row_pos >= h);
        mag = '0;
        d = DIR_HORZ;
        c = col_pos;
        r = row_pos;
        produced = 1'b0;
        res = '0;
        // A flush inside the frame is ignored entirely.
        if (!draining && fl) return;
        if (!draining)
        begin
            mag = mag_in;
            d = angle_to_dir(ang_in);
        end
        if (c >= w) c = 0;

        // Shift the line memory and the window by one column.
        top = line_mag[c];
        mid = line_mag[MAX_WIDTH + c];
        line_mag[c] = mid;
        line_mag[MAX_WIDTH + c] = mag;
        for (k = 0; k < 3; k++)
        begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = mag;
        dir_centre = dir_next;
        dir_next = line_dir[c];
        line_dir[c] = d;

        col_pos = c + 1;
        if (col_pos >= w)
        begin
            col_pos = 0;
            row_pos = (r + 1) & 12'hFFF;
        end

        // The center trails the input by one row and one pixel.
        if (r >= 2 || (r == 1 && c >= 1))
        begin
            if (c >= 1)
            begin
                cr = r - 1;
                cc = c - 1;
            end
            else
            begin
                cr = r - 2;
                cc = w - 1;
            end
            case (dir_t'(dir_centre))
                DIR_HORZ:      begin dr = 0;  dc = -1; end
                DIR_DIAG_DOWN: begin dr = -1; dc = -1; end
                DIR_VERT:      begin dr = -1; dc = 0;  end
                default:       begin dr = -1; dc = 1;  end
            endcase
            centre = win[1][1];
            kept = centre;
            // The two neighbors are mirror images; those outside the image never suppress.
            for (k = 0; k < 2; k++)
            begin
                nr = cr + dr;
                nc = cc + dc;
                if (nr >= 0 && nr < h && nc >= 0 && nc < w && centre < win[1 + dr][1 + dc])
                    kept = '0;
                dr = -dr;
                dc = -dc;
            end
            res.kept = kept;
            res.last = (cr == h - 1) && (cc == w - 1);
            produced = 1'b1;
            if (res.last)
            begin
                col_pos = 0;
                row_pos = 0;
            end
        end
    endtask

    function automatic logic [MAG_BITS-1:0] rand_mag();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return MAG_BITS'($urandom_range(0, 7));
            4:          return '0;
            5:          return '1;
            default:    return MAG_BITS'($urandom_range(0, 65535));
        endcase
    endfunction

    // Half the angles sit on or next to a direction or fold boundary up to 360 degrees.
    function automatic logic [ANGLE_BITS-1:0] rand_angle();
        case ($urandom_range(0, 3))
            0, 1:    return ANGLE_BITS'($urandom_range(0, 4095));
            2:       return ANGLE_BITS'(225 + 450 * $urandom_range(0, 7) + $urandom_range(0, 1));
            default: return ANGLE_BITS'(1800 * $urandom_range(0, 2) - $urandom_range(0, 1));
        endcase
    endfunction

    function automatic nms_vector_t random_item(input bit fl);
        nms_vector_t v;
        v = '0;
        v.mag = rand_mag();
        v.ang = rand_angle();
        v.fl = fl;
        return v;
    endfunction

    // Offer one input transaction, then predict what it causes once it is taken.
    task automatic send_item(input nms_vector_t v);
        bit          produced;
        nms_result_t res;
        while (!steady && ($urandom_range(0, 99) < 25))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        pixel_magnitude <= v.mag;
        angle_tenths    <= v.ang;
        flush           <= v.fl;
        do @(posedge clk); while (!in_fire);
        nms_step(v.mag, v.ang, v.fl, produced, res);
        if (produced)
        begin
            if (v.fixed_exp)
            begin
                res.kept = v.exp_kept;
                res.last = v.exp_last;
            end
            pending_results = {pending_results, res};
        end
        items_sent++;
    endtask

    // Hold the input side until every expected result has come back.
    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Idle point for register writes: items that cause no result may still be in flight.
    task automatic settle();
        wait_results();
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_fire);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == CFG_IDX_WIDTH || idx == CFG_IDX_HEIGHT)
        begin
            if (idx == CFG_IDX_WIDTH)
                width_reg = data;
            else
                height_reg = data;
            col_pos = 0;
            row_pos = 0;
        end
        @(posedge clk);
    endtask

    // One raster frame with stray flushes, an optional pause, and the drain at the end.
    // A frame that is cut short stops partway and is never drained; a nonzero cap
    // bounds how many pixels it gets.
    task automatic run_frame(input bit cut_short, input int pixel_cap);
        int w;
        int h;
        int total;
        int stop_at;
        int pause_at;
        int i;
        w = width_used();
        h = height_used();
        total = w * h;
        stop_at = cut_short ? $urandom_range(1, total - 1) : total;
        if (pixel_cap > 0 && stop_at > pixel_cap) stop_at = pixel_cap;
        pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, total - 1) : -1;
        for (i = 0; i < stop_at; i++)
        begin
            if (i == pause_at) wait_results();
            if ($urandom_range(0, 19) == 0) send_item(random_item(1'b1));
            send_item(random_item(1'b0));
        end
        if (!cut_short)
        begin
            for (i = 0; i <= w; i++) send_item(random_item($urandom_range(0, 4) != 0));
            if ($urandom_range(0, 3) == 0) send_item(random_item(1'b1));
        end
    endtask

    // Result checking, receiver back-pressure and the stall watchdog.
    always @(posedge clk)
    begin
        nms_result_t want;
        if (rst_n)
        begin
            out_ready <= steady || ($urandom_range(0, 99) >= 25);
            if (out_fire)
            begin
                results_seen++;
                if (last_seen === 1'b1) frames_done++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, kept_magnitude %h frame_last %b",
                             $time, kept_seen, last_seen);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (kept_seen !== want.kept)
                    begin
                        $display("%0t: kept_magnitude expected %h actual %h",
                                 $time, want.kept, kept_seen);
                        errors++;
                    end
                    if (last_seen !== want.last)
                    begin
                        $display("%0t: frame_last expected %b actual %b",
                                 $time, want.last, last_seen);
                        errors++;
                    end
                end
            end
            if (in_fire || out_fire || cfg_fire)
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, pending_results.size());
                $display("canny_non_maximum_suppression_core: mismatch");
                $finish;
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        int i;
        int f;
        int w;
        int h;
        int nframes;
        int start_items;
        bit cut;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Unused slots first, then sizes below the minimum, which clamp to 3x3.
        write_reg(CFG_IDX_SPARE_A, 12'hFFF);
        write_reg(CFG_IDX_SPARE_B, 12'h000);
        write_reg(CFG_IDX_WIDTH, 12'd0);
        write_reg(CFG_IDX_HEIGHT, 12'd2);
        for (i = 0; i < $size(directed_rows); i++) send_item(directed_rows[i]);
        settle();

        // Widest line, clamped from the largest register value, started but not finished,
        // then a whole frame, all with no random input gaps and no output back-pressure.
        steady = 1'b1;
        write_reg(CFG_IDX_WIDTH, 12'hFFF);
        write_reg(CFG_IDX_HEIGHT, 12'd3);
        run_frame(1'b1, WIDE_PIXELS);
        settle();
        write_reg(CFG_IDX_WIDTH, 12'd12);
        write_reg(CFG_IDX_HEIGHT, 12'd8);
        run_frame(1'b0, 0);
        settle();
        steady = 1'b0;

        // Tallest frame at the narrowest width, stopped after its first rows.
        write_reg(CFG_IDX_WIDTH, 12'd3);
        write_reg(CFG_IDX_HEIGHT, 12'd2048);
        run_frame(1'b1, TALL_PIXELS);

        // Random phases of small frames, some cut short, some sizes left as they were.
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            settle();
            w = $urandom_range(3, 12);
            h = $urandom_range(3, 8);
            if ($urandom_range(0, 2) != 0)
                write_reg(CFG_IDX_WIDTH, (w == 3) ? CFG_BITS'($urandom_range(0, 3)) : CFG_BITS'(w));
            write_reg(CFG_IDX_HEIGHT, (h == 3) ? CFG_BITS'($urandom_range(0, 3)) : CFG_BITS'(h));
            if ($urandom_range(0, 7) == 0)
                write_reg($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                          CFG_BITS'($urandom_range(0, 4095)));
            nframes = $urandom_range(1, 3);
            for (f = 0; f < nframes; f++)
            begin
                cut = ($urandom_range(0, 6) == 0);
                run_frame(cut, 0);
                if (cut) break;
            end
        end

        wait_results();
        repeat (TAIL_TICKS) @(posedge clk);
        $display("Sent %0d input transactions and %0d register writes over clamped, widest,",
                 items_sent, reg_writes);
        $display("tallest and random small frames; checked %0d results over %0d completed frames.",
                 results_seen, frames_done);
        if (errors == 0)
            $display("canny_non_maximum_suppression_core: match");
        else
            $display("canny_non_maximum_suppression_core: mismatch");
        $finish;
    end

endmodule
